// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define HDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define HDS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/hds_pkg.sv
`default_nettype none

package hds_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int TEMP_W     = 16;
	localparam int ROW_W      = 16;
	localparam int OUT_COL_W  = 10;
	localparam int COEFF_W    = 15;
	localparam int GWIDTH_W   = 11;
	localparam int HEIGHT_W   = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int LAP_W      = 19;
	localparam int PROD_W     = COEFF_W + 1 + LAP_W;
	localparam int FRAC_W     = 16;
	localparam int INC_W      = PROD_W - FRAC_W;
	localparam int SUM_W      = INC_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = FIFO_AW + 1;

	localparam logic [COEFF_W-1:0]  COEFF_RESET  = COEFF_W'(16384);
	localparam logic [GWIDTH_W-1:0] WIDTH_RESET  = GWIDTH_W'(200);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(200);
	localparam logic [GWIDTH_W-1:0] WIDTH_MIN    = GWIDTH_W'(3);
	localparam logic [GWIDTH_W-1:0] WIDTH_MAX    = GWIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_COEFF  = 2'd0;
	localparam reg_idx_t REG_WIDTH  = 2'd1;
	localparam reg_idx_t REG_HEIGHT = 2'd2;

	typedef struct packed {
		logic [TEMP_W-1:0] up;
		logic [TEMP_W-1:0] left;
		logic [TEMP_W-1:0] centre;
		logic [TEMP_W-1:0] right;
	} window_t;

	typedef struct packed {
		logic [TEMP_W-1:0]    temp;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 frame_done;
		logic                 run_last;
	} result_t;

	typedef struct packed {
		logic a;
		logic b;
	} push_t;

endpackage

`default_nettype wire

// File: hw/rtl/hds_line_buf.sv
`default_nettype none

module hds_line_buf
	import hds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              acc,
	input  wire logic [COL_W-1:0]  wr_col,
	input  wire logic [COL_W-1:0]  rd_col,
	input  wire logic [TEMP_W-1:0] wdata,
	output window_t                win
);

	logic [TEMP_W-1:0] prior_mem [MAX_WIDTH];
	logic [TEMP_W-1:0] older_mem [MAX_WIDTH];
	logic [TEMP_W-1:0] prior_c_q;
	logic [TEMP_W-1:0] prior_r_q;
	logic [TEMP_W-1:0] older_q;
	logic [TEMP_W-1:0] left_q;
	logic [COL_W-1:0]  rd_next;

	assign rd_next = rd_col + COL_W'(1);

	// write the current column, prefetch the next one
	always_ff @(posedge clk) begin
		if (acc) begin
			prior_mem[wr_col] <= wdata;
			older_mem[wr_col] <= prior_c_q;
			prior_c_q         <= prior_mem[rd_col];
			prior_r_q         <= prior_mem[rd_next];
			older_q           <= older_mem[rd_col];
			left_q            <= prior_c_q;
		end
	end

	assign win.up     = older_q;
	assign win.left   = left_q;
	assign win.centre = prior_c_q;
	assign win.right  = prior_r_q;

endmodule

`default_nettype wire

// File: hw/rtl/hds_update.sv
`default_nettype none

module hds_update
	import hds_pkg::*;
(
	input  wire logic [COEFF_W-1:0]     coeff,
	input  wire logic signed [LAP_W-1:0] lap,
	input  wire logic [TEMP_W-1:0]      centre,
	input  wire logic                   border,
	output logic [TEMP_W-1:0]           value
);

	logic signed [PROD_W-1:0] prod;
	logic signed [INC_W-1:0]  inc;
	logic signed [SUM_W-1:0]  sum;

	assign prod = PROD_W'($signed({1'b0, coeff})) * PROD_W'(lap);
	assign inc  = prod[PROD_W-1:FRAC_W];
	assign sum  = $signed({{(SUM_W-TEMP_W){1'b0}}, centre}) + SUM_W'(inc);

	always_comb begin
		if (border) begin
			value = centre;
		end else if (sum[SUM_W-1]) begin
			value = '0;
		end else if (sum[SUM_W-2:TEMP_W] != '0) begin
			value = '1;
		end else begin
			value = sum[TEMP_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/hds_res_fifo.sv
`default_nettype none

module hds_res_fifo
	import hds_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire push_t        push,
	input  wire result_t      res_a,
	input  wire result_t      res_b,
	input  wire logic         pop,
	output result_t           head,
	output logic [CNT_W-1:0]  count
);

	result_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic [FIFO_AW-1:0]   wr_next;
	logic [CNT_W-1:0]     n_push;

	assign wr_next = wr_ptr_q + FIFO_AW'(1);
	assign n_push  = CNT_W'(push.a) + CNT_W'(push.b);

	always_ff @(posedge clk) begin
		if (push.a) begin
			mem[wr_ptr_q] <= res_a;
		end
		if (push.b) begin
			mem[wr_next] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

	assign head  = mem[rd_ptr_q];
	assign count = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/heat_diffusion_stencil.sv
// Five-point heat-diffusion stencil, one explicit time step per frame pass.
// Input channel: temperature beats in raster order, in_valid / in_stall.
// Output channel: result beats (new_temperature, out_row, out_col,
// frame_done, run_last), out_valid / out_stall.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 coefficient, 1 grid width, 2 grid height); write only while idle.
// Throughput: one input beat per cycle while in_stall is low; a beat of the
// last row gives two results, which leave through the single output port.
// Row 0 gives no result.
// A result passes the stage-1 registers and then the result queue before it
// is on the output.
// The line buffers prefetch the next column at each accepted beat, so a
// beat waits for no memory read.
// Reset clears positions, registers to their defaults and the result queue.
// The line buffers are not cleared: a full row 0 and row 1 refill them.
// When the receiver stalls, results wait in a four-entry queue and
// in_stall rises once the queue has no room for the beats in flight.
`default_nettype none

module heat_diffusion_stencil
	import hds_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [TEMP_W-1:0]    temperature,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [TEMP_W-1:0]         new_temperature,
	output logic [ROW_W-1:0]          out_row,
	output logic [OUT_COL_W-1:0]      out_col,
	output logic                      frame_done,
	output logic                      run_last
);

	logic [COEFF_W-1:0]  coeff_q;
	logic [GWIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;

	logic [GWIDTH_W-1:0] w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                last_row;
	logic                last_col;
	logic                acc;
	logic [COL_W-1:0]    col_next;
	window_t             win;
	logic signed [LAP_W-1:0] lap;

	logic                    valid_s1;
	logic [TEMP_W-1:0]       temp_s1;
	logic [TEMP_W-1:0]       centre_s1;
	logic signed [LAP_W-1:0] lap_s1;
	logic [ROW_W-1:0]        row_s1;
	logic [COL_W-1:0]        col_s1;
	logic                    emit_s1;
	logic                    last_row_s1;
	logic                    last_col_s1;
	logic                    border_s1;

	logic [TEMP_W-1:0]   upd_value;
	push_t               push;
	result_t             res_a;
	result_t             res_b;
	result_t             head;
	logic [CNT_W-1:0]    count;
	logic [CNT_W-1:0]    pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q  <= COEFF_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEFF: begin
					coeff_q <= cfg_data[COEFF_W-1:0];
				end
				REG_WIDTH: begin
					width_q <= cfg_data[GWIDTH_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= cfg_data[HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_MIN) begin
			w_eff = WIDTH_MIN;
		end else if (width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = width_q;
		end
		if (height_q < HEIGHT_MIN) begin
			h_eff = HEIGHT_MIN;
		end else begin
			h_eff = height_q;
		end
	end

	assign last_col = GWIDTH_W'(col_q) >= (w_eff - GWIDTH_W'(1));
	assign last_row = row_q >= (h_eff - HEIGHT_W'(1));
	assign acc      = in_valid && !in_stall;
	assign col_next = last_col ? '0 : col_q + COL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			col_q <= col_next;
			if (last_col) begin
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end
		end
	end

	hds_line_buf u_line_buf (
		.clk    (clk),
		.acc    (acc),
		.wr_col (col_q),
		.rd_col (col_next),
		.wdata  (temperature),
		.win    (win)
	);

	assign lap = LAP_W'(win.up) + LAP_W'(temperature) + LAP_W'(win.left)
		+ LAP_W'(win.right) - LAP_W'({win.centre, 2'b00});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			temp_s1     <= temperature;
			centre_s1   <= win.centre;
			lap_s1      <= lap;
			row_s1      <= row_q;
			col_s1      <= col_q;
			emit_s1     <= row_q != '0;
			last_row_s1 <= last_row;
			last_col_s1 <= last_col;
			border_s1   <= (row_q == ROW_W'(1)) || (col_q == '0) || last_col;
		end
	end

	hds_update u_update (
		.coeff  (coeff_q),
		.lap    (lap_s1),
		.centre (centre_s1),
		.border (border_s1),
		.value  (upd_value)
	);

	assign push.a = valid_s1 && emit_s1;
	assign push.b = valid_s1 && emit_s1 && last_row_s1;

	assign res_a.temp       = upd_value;
	assign res_a.row        = row_s1 - ROW_W'(1);
	assign res_a.col        = OUT_COL_W'(col_s1);
	assign res_a.frame_done = 1'b0;
	assign res_a.run_last   = !last_row_s1;

	assign res_b.temp       = temp_s1;
	assign res_b.row        = row_s1;
	assign res_b.col        = OUT_COL_W'(col_s1);
	assign res_b.frame_done = last_col_s1;
	assign res_b.run_last   = 1'b1;

	hds_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res_a  (res_a),
		.res_b  (res_b),
		.pop    (out_valid && !out_stall),
		.head   (head),
		.count  (count)
	);

	// reserve room for the beat still in flight
	assign pend     = CNT_W'(push.a) + CNT_W'(push.b);
	assign in_stall = (count + pend) > CNT_W'(FIFO_DEPTH - 2);

	assign out_valid       = count != '0;
	assign new_temperature = head.temp;
	assign out_row         = head.row;
	assign out_col         = head.col;
	assign frame_done      = head.frame_done;
	assign run_last        = head.run_last;

endmodule

`default_nettype wire

// File: hw/rtl/hds_checker.sv
`default_nettype none

`include "assert_macros.svh"

module hds_checker
	import hds_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [TEMP_W-1:0]    new_temperature,
	input wire logic [ROW_W-1:0]     out_row,
	input wire logic [OUT_COL_W-1:0] out_col,
	input wire logic                 frame_done,
	input wire logic                 run_last
);

	`HDS_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "output valid during reset")

	`HDS_ASSERT(a_done_is_last, out_valid && frame_done |-> run_last && out_row != '0, "frame end not on last result of its beat")

	`HDS_ASSERT(a_pair_follows, out_valid && !out_stall && !run_last |=> out_valid && out_row == $past(out_row) + 16'd1 && out_col == $past(out_col), "second result of a beat missing or misplaced")

	`HDS_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(new_temperature) && $stable(out_row) && $stable(out_col), "stalled result changed")

endmodule

bind heat_diffusion_stencil hds_checker u_hds_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.new_temperature (new_temperature),
	.out_row         (out_row),
	.out_col         (out_col),
	.frame_done      (frame_done),
	.run_last        (run_last)
);

`default_nettype wire
